FILE: hdl/gha_pkg.sv
// Shared constants, command codes and controller/datapath interface types.
package gha_pkg;

	localparam int INDEX_BITS = 10;
	localparam int GEN_BITS   = 8;
	localparam int HANDLE_W   = INDEX_BITS + GEN_BITS;
	localparam int SLOTS      = 1 << INDEX_BITS;
	localparam int CNT_W      = INDEX_BITS + 1;
	localparam int THR_W      = 10;
	localparam int THR_RESET  = 16;
	localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam int CMD_W      = 2;
	localparam int IN_TDATA_W  = ((HANDLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((HANDLE_W + 2 + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_ALIVE  = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_e_t;

	typedef struct packed {
		logic load;
		logic gen_re;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop;
	} dp_status_t;

endpackage

FILE: hdl/gha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/gha_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module gha_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gha_pkg::CMD_W-1:0]    in_cmd,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  gha_pkg::dp_status_t          status,
	output gha_pkg::ctrl_cmd_t           cmd
);
	import gha_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN_RD,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign cmd.load   = accept;
	assign cmd.gen_re = (state_q == ST_GEN_RD);
	assign cmd.commit = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_cmd == CMD_CREATE && status.pop) begin
							state_q <= ST_GEN_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_GEN_RD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/gha_dp.sv
// Datapath: generation memory, free-slot FIFO, counters and the result register.
module gha_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gha_pkg::ctrl_cmd_t             cmd,
	output gha_pkg::dp_status_t            status,
	input  logic [gha_pkg::CMD_W-1:0]      in_cmd,
	input  logic [gha_pkg::HANDLE_W-1:0]   handle_in,
	input  logic                           cfg_we,
	input  logic [gha_pkg::THR_W-1:0]      cfg_wdata,
	output logic [gha_pkg::HANDLE_W-1:0]   handle_out,
	output logic                           is_alive,
	output logic                           wrapped
);
	import gha_pkg::*;

	cmd_e_t                cmd_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [GEN_BITS-1:0]   gen_q;
	logic [INDEX_BITS-1:0] head_q;
	logic [INDEX_BITS-1:0] tail_q;
	logic [CNT_W-1:0]      count_q;
	logic [INDEX_BITS-1:0] fresh_q;
	logic [THR_W-1:0]      thr_q;

	logic [GEN_BITS-1:0]   gen_rdata;
	logic [INDEX_BITS-1:0] fifo_rdata;
	logic                  gen_re;
	logic [INDEX_BITS-1:0] gen_raddr;
	logic                  gen_we;
	logic [INDEX_BITS-1:0] gen_waddr;
	logic [GEN_BITS-1:0]   gen_wdata;
	logic                  fifo_we;

	logic                  match;
	logic                  fresh_wrap;
	logic [INDEX_BITS-1:0] fresh_slot;
	logic                  is_create;
	logic                  is_delete;
	logic                  do_pop;
	logic                  do_fresh;

	assign status.pop = CMP_W'(count_q) > CMP_W'(thr_q);

	assign is_create  = (cmd_q == CMD_CREATE);
	assign is_delete  = (cmd_q == CMD_DELETE);
	assign match      = (idx_q < fresh_q) && (gen_rdata == gen_q);
	assign fresh_wrap = (fresh_q == {INDEX_BITS{1'b1}});
	assign fresh_slot = fresh_wrap ? '0 : fresh_q;
	assign do_pop     = cmd.commit && is_create && status.pop;
	assign do_fresh   = cmd.commit && is_create && !status.pop;

	assign gen_re    = cmd.load || cmd.gen_re;
	assign gen_raddr = cmd.load ? handle_in[INDEX_BITS-1:0] : fifo_rdata;
	assign gen_we    = do_fresh || (cmd.commit && is_delete && match);
	assign gen_waddr = is_create ? fresh_slot : idx_q;
	assign gen_wdata = is_create ? '0 : gen_q + GEN_BITS'(1);
	assign fifo_we   = cmd.commit && is_delete && match && !count_q[INDEX_BITS];

	gha_ram #(
		.WIDTH (GEN_BITS),
		.DEPTH (SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gha_ram #(
		.WIDTH (INDEX_BITS),
		.DEPTH (SLOTS)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_q),
		.wdata (idx_q),
		.re    (cmd.load),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			thr_q   <= THR_W'(THR_RESET);
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (do_pop) begin
				head_q  <= head_q + INDEX_BITS'(1);
				count_q <= count_q - CNT_W'(1);
			end
			if (fifo_we) begin
				tail_q  <= tail_q + INDEX_BITS'(1);
				count_q <= count_q + CNT_W'(1);
			end
			if (do_fresh) begin
				fresh_q <= fresh_slot + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_e_t'(in_cmd);
			idx_q <= handle_in[INDEX_BITS-1:0];
			gen_q <= handle_in[HANDLE_W-1:INDEX_BITS];
		end
		if (cmd.commit) begin
			case (cmd_q)
				CMD_CREATE: begin
					handle_out <= status.pop ? {gen_rdata, fifo_rdata} :
						HANDLE_W'(fresh_slot);
					is_alive   <= 1'b0;
					wrapped    <= !status.pop && fresh_wrap;
				end
				CMD_ALIVE, CMD_DELETE: begin
					handle_out <= '0;
					is_alive   <= match;
					wrapped    <= 1'b0;
				end
				default: begin
					handle_out <= '0;
					is_alive   <= 1'b0;
					wrapped    <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: hdl/generational_handle_allocator_top.sv
// Top level of the generational handle allocator: controller, datapath and stream ports.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: command; tdata: handle_in
//   m_axis    out        tdata: handle_out, is_alive, wrapped
//   cfg       in         min_free_threshold write
//
// A create that reuses a freed slot passes through ST_GEN_RD between acceptance and the
// result register; every other transaction goes straight from acceptance to ST_DONE,
// and a new transaction is accepted only once the last has left ST_DONE. The free-slot
// FIFO read followed by the generation memory read, both with registered read data,
// makes the reusing create the longer path. Reset clears the FIFO pointers and counts
// and sets the threshold to 16; the memories are not cleared.
// While a result waits in the output register the next transaction is accepted and
// held in its final step until the register is free.
module generational_handle_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// handle_in
	input  logic [gha_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic [gha_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// handle_out, is_alive, wrapped
	output logic [gha_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [gha_pkg::THR_W-1:0]       cfg_wdata
);
	import gha_pkg::*;

	ctrl_cmd_t             cmd;
	dp_status_t            status;
	logic [HANDLE_W-1:0]   handle_out;
	logic                  is_alive;
	logic                  wrapped;

	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	gha_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_cmd     (s_axis_tuser),
		.handle_in  (s_axis_tdata[HANDLE_W-1:0]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.handle_out (handle_out),
		.is_alive   (is_alive),
		.wrapped    (wrapped)
	);

	assign m_axis_tdata = OUT_TDATA_W'({wrapped, is_alive, handle_out});

endmodule
